>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect clk and arst_n in the scope where they are used.
// The antecedent and consequent hold in the same cycle.
`define LBPQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbpq: assertion failed");

// The consequent holds in the cycle after the antecedent.
`define LBPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbpq: assertion failed");

`endif

>>> design/lbpq_pkg.sv
package lbpq_pkg;

	localparam int ANGLE_W  = 13;
	localparam int LIMIT_W  = 16;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int NUM_CHK  = 5;

	// Bit positions in check_mask.
	localparam int CHK_ANGLE = 0;
	localparam int CHK_SLOPE = 1;
	localparam int CHK_X     = 2;
	localparam int CHK_Y     = 3;
	localparam int CHK_LEN   = 4;

	typedef enum logic [2:0] {
		REG_ANGLE = 3'd0,
		REG_SLOPE = 3'd1,
		REG_XOFF  = 3'd2,
		REG_YOFF  = 3'd3,
		REG_LEN   = 3'd4,
		REG_LARGE = 3'd5
	} reg_idx_t;

	localparam logic [LIMIT_W-1:0] RST_ANGLE = 16'd96;
	localparam logic [LIMIT_W-1:0] RST_SLOPE = 16'd305;
	localparam logic [LIMIT_W-1:0] RST_XOFF  = 16'd1152;
	localparam logic [LIMIT_W-1:0] RST_YOFF  = 16'd128;
	localparam logic [LIMIT_W-1:0] RST_LEN   = 16'd128;
	localparam logic [LIMIT_W-1:0] RST_LARGE = 16'd640;

	typedef struct packed {
		logic [LIMIT_W-1:0] angle;
		logic [LIMIT_W-1:0] slope;
		logic [LIMIT_W-1:0] xoff;
		logic [LIMIT_W-1:0] yoff;
		logic [LIMIT_W-1:0] len;
		logic [LIMIT_W-1:0] large_lim;
	} limits_t;

endpackage

>>> design/lbpq_cfg.sv
module lbpq_cfg
	import lbpq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output limits_t           limits
);

	limits_t  limits_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign limits = limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.angle     <= RST_ANGLE;
			limits_q.slope     <= RST_SLOPE;
			limits_q.xoff      <= RST_XOFF;
			limits_q.yoff      <= RST_YOFF;
			limits_q.len       <= RST_LEN;
			limits_q.large_lim <= RST_LARGE;
		end else if (wr) begin
			// Writes to the two unused indexes are dropped.
			unique case (idx)
				REG_ANGLE: limits_q.angle     <= pwdata[LIMIT_W-1:0];
				REG_SLOPE: limits_q.slope     <= pwdata[LIMIT_W-1:0];
				REG_XOFF:  limits_q.xoff      <= pwdata[LIMIT_W-1:0];
				REG_YOFF:  limits_q.yoff      <= pwdata[LIMIT_W-1:0];
				REG_LEN:   limits_q.len       <= pwdata[LIMIT_W-1:0];
				REG_LARGE: limits_q.large_lim <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ANGLE: prdata = DATA_W'(limits_q.angle);
			REG_SLOPE: prdata = DATA_W'(limits_q.slope);
			REG_XOFF:  prdata = DATA_W'(limits_q.xoff);
			REG_YOFF:  prdata = DATA_W'(limits_q.yoff);
			REG_LEN:   prdata = DATA_W'(limits_q.len);
			REG_LARGE: prdata = DATA_W'(limits_q.large_lim);
			default:   prdata = '0;
		endcase
	end

endmodule

>>> design/lbpq_diff.sv
module lbpq_diff
	import lbpq_pkg::*;
#(
	parameter int CB = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [ANGLE_W-1:0] left_angle,
	input  logic [ANGLE_W-1:0] right_angle,
	input  logic [CB-1:0]      left_x,
	input  logic [CB-1:0]      left_y,
	input  logic [CB-1:0]      right_x,
	input  logic [CB-1:0]      right_y,
	input  logic [CB-1:0]      left_length,
	input  logic [CB-1:0]      right_length,
	output logic               v_s1,
	output logic [ANGLE_W-1:0] adiff_s1,
	output logic [CB-1:0]      dx_s1,
	output logic [CB-1:0]      dy_s1,
	output logic [CB:0]        sum_s1,
	output logic [CB-1:0]      mx_s1,
	output logic [CB-1:0]      ldiff_s1
);

	logic [ANGLE_W:0]   ad;
	logic [ANGLE_W:0]   ad_abs;
	logic [CB-1:0]      dx, dy, mx, ldiff;
	logic [CB:0]        sum;

	always_comb begin
		ad     = {left_angle[ANGLE_W-1], left_angle} - {right_angle[ANGLE_W-1], right_angle};
		ad_abs = ad[ANGLE_W] ? -ad : ad;
		dx     = (left_x >= right_x) ? left_x - right_x : right_x - left_x;
		dy     = (left_y >= right_y) ? left_y - right_y : right_y - left_y;
		mx     = (left_length >= right_length) ? left_length : right_length;
		ldiff  = (left_length >= right_length) ? left_length - right_length
		                                       : right_length - left_length;
		sum    = (CB+1)'(left_length) + (CB+1)'(right_length);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			// The largest magnitude of two 13-bit angles' difference fits 13 bits.
			adiff_s1 <= ad_abs[ANGLE_W-1:0];
			dx_s1    <= dx;
			dy_s1    <= dy;
			sum_s1   <= sum;
			mx_s1    <= mx;
			ldiff_s1 <= ldiff;
		end
	end

endmodule

>>> design/lbpq_prod.sv
module lbpq_prod
	import lbpq_pkg::*;
#(
	parameter int CB = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  limits_t              limits,
	input  logic                 v_s1,
	input  logic [ANGLE_W-1:0]   adiff_s1,
	input  logic [CB-1:0]        dx_s1,
	input  logic [CB-1:0]        dy_s1,
	input  logic [CB:0]          sum_s1,
	input  logic [CB-1:0]        mx_s1,
	input  logic [CB-1:0]        ldiff_s1,
	output logic                 v_s2,
	output logic                 angle_ok_s2,
	output logic [LIMIT_W+CB-1:0] p_slope_s2,
	output logic [LIMIT_W+CB:0]   p_x_s2,
	output logic [LIMIT_W+CB:0]   p_y_s2,
	output logic [LIMIT_W+CB:0]   p_large_s2,
	output logic [LIMIT_W+CB-1:0] p_len_s2,
	output logic [CB-1:0]        dx_s2,
	output logic [CB-1:0]        dy_s2,
	output logic [CB-1:0]        ldiff_s2
);

	localparam int PN = LIMIT_W + CB;
	localparam int PS = LIMIT_W + CB + 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			angle_ok_s2 <= LIMIT_W'(adiff_s1) < limits.angle;
			p_slope_s2  <= PN'(limits.slope) * PN'(dx_s1);
			p_x_s2      <= PS'(limits.xoff) * PS'(sum_s1);
			p_y_s2      <= PS'(limits.yoff) * PS'(sum_s1);
			p_large_s2  <= PS'(limits.large_lim) * PS'(sum_s1);
			p_len_s2    <= PN'(limits.len) * PN'(mx_s1);
			dx_s2       <= dx_s1;
			dy_s2       <= dy_s1;
			ldiff_s2    <= ldiff_s1;
		end
	end

endmodule

>>> design/lbpq_judge.sv
module lbpq_judge
	import lbpq_pkg::*;
#(
	parameter int CB = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  v_s2,
	input  logic                  angle_ok_s2,
	input  logic [LIMIT_W+CB-1:0] p_slope_s2,
	input  logic [LIMIT_W+CB:0]   p_x_s2,
	input  logic [LIMIT_W+CB:0]   p_y_s2,
	input  logic [LIMIT_W+CB:0]   p_large_s2,
	input  logic [LIMIT_W+CB-1:0] p_len_s2,
	input  logic [CB-1:0]         dx_s2,
	input  logic [CB-1:0]         dy_s2,
	input  logic [CB-1:0]         ldiff_s2,
	output logic                  v_s3,
	output logic                  pair_ok_s3,
	output logic [NUM_CHK-1:0]    mask_s3,
	output logic                  large_s3
);

	localparam int PW = LIMIT_W + CB + 1;

	logic [PW-1:0]      dx9, dy8, dy9, ld8;
	logic [NUM_CHK-1:0] mask;
	logic               large_hit;

	// A zero sum or zero dx gives a zero product, so the strict less-than
	// compares on that product fail just as an infinite or undefined ratio would.
	always_comb begin
		dx9 = PW'({dx_s2, 9'b0});
		dy8 = PW'({dy_s2, 8'b0});
		dy9 = PW'({dy_s2, 9'b0});
		ld8 = PW'({ldiff_s2, 8'b0});
		mask            = '0;
		mask[CHK_ANGLE] = angle_ok_s2;
		mask[CHK_SLOPE] = dy8 < PW'(p_slope_s2);
		mask[CHK_X]     = dx9 < p_x_s2;
		mask[CHK_Y]     = dy9 < p_y_s2;
		mask[CHK_LEN]   = ld8 < PW'(p_len_s2);
		large_hit       = dx9 > p_large_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s2) begin
			mask_s3    <= mask;
			pair_ok_s3 <= &mask;
			large_s3   <= large_hit;
		end
	end

endmodule

>>> design/light_bar_pair_qualifier_top.sv
// Channel   Handshake               Payload
// in        in_valid / in_stall     left/right angle, x, y, length
// out       out_valid / out_stall   pair_ok, check_mask, large_type
// apb       psel/penable/pready     paddr, pwdata, prdata
//
// One pair is accepted every cycle while in_stall is low; each result
// passes through the three register stages (differences, products,
// compares) in that order. Each stage moves on when it is empty or the
// stage after it moves, so bubbles close up and in_stall rises only when
// all stages are full and out_stall is high. Reset clears the valid bits
// and loads the limit registers with their defaults.
`include "assert_macros.svh"

module light_bar_pair_qualifier_top
	import lbpq_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [ANGLE_W-1:0] left_angle,
	input  logic signed [ANGLE_W-1:0] right_angle,
	input  logic [COORD_BITS-1:0]    left_x,
	input  logic [COORD_BITS-1:0]    left_y,
	input  logic [COORD_BITS-1:0]    right_x,
	input  logic [COORD_BITS-1:0]    right_y,
	input  logic [COORD_BITS-1:0]    left_length,
	input  logic [COORD_BITS-1:0]    right_length,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     pair_ok,
	output logic [NUM_CHK-1:0]       check_mask,
	output logic                     large_type,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready
);

	localparam int CB = COORD_BITS;

	limits_t limits;

	logic en1, en2, en3;
	logic v1, v2, v3;

	logic [ANGLE_W-1:0]   adiff_s1;
	logic [CB-1:0]        dx_s1, dy_s1, mx_s1, ldiff_s1;
	logic [CB:0]          sum_s1;

	logic                 angle_ok_s2;
	logic [LIMIT_W+CB-1:0] p_slope_s2, p_len_s2;
	logic [LIMIT_W+CB:0]   p_x_s2, p_y_s2, p_large_s2;
	logic [CB-1:0]        dx_s2, dy_s2, ldiff_s2;

	assign pready   = 1'b1;
	assign en3      = !v3 || !out_stall;
	assign en2      = !v2 || en3;
	assign en1      = !v1 || en2;
	assign in_stall = !en1;
	assign out_valid = v3;

	lbpq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.limits  (limits)
	);

	lbpq_diff #(.CB(CB)) u_diff (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en1),
		.in_valid     (in_valid),
		.left_angle   (left_angle),
		.right_angle  (right_angle),
		.left_x       (left_x),
		.left_y       (left_y),
		.right_x      (right_x),
		.right_y      (right_y),
		.left_length  (left_length),
		.right_length (right_length),
		.v_s1         (v1),
		.adiff_s1     (adiff_s1),
		.dx_s1        (dx_s1),
		.dy_s1        (dy_s1),
		.sum_s1       (sum_s1),
		.mx_s1        (mx_s1),
		.ldiff_s1     (ldiff_s1)
	);

	lbpq_prod #(.CB(CB)) u_prod (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en2),
		.limits      (limits),
		.v_s1        (v1),
		.adiff_s1    (adiff_s1),
		.dx_s1       (dx_s1),
		.dy_s1       (dy_s1),
		.sum_s1      (sum_s1),
		.mx_s1       (mx_s1),
		.ldiff_s1    (ldiff_s1),
		.v_s2        (v2),
		.angle_ok_s2 (angle_ok_s2),
		.p_slope_s2  (p_slope_s2),
		.p_x_s2      (p_x_s2),
		.p_y_s2      (p_y_s2),
		.p_large_s2  (p_large_s2),
		.p_len_s2    (p_len_s2),
		.dx_s2       (dx_s2),
		.dy_s2       (dy_s2),
		.ldiff_s2    (ldiff_s2)
	);

	lbpq_judge #(.CB(CB)) u_judge (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en3),
		.v_s2        (v2),
		.angle_ok_s2 (angle_ok_s2),
		.p_slope_s2  (p_slope_s2),
		.p_x_s2      (p_x_s2),
		.p_y_s2      (p_y_s2),
		.p_large_s2  (p_large_s2),
		.p_len_s2    (p_len_s2),
		.dx_s2       (dx_s2),
		.dy_s2       (dy_s2),
		.ldiff_s2    (ldiff_s2),
		.v_s3        (v3),
		.pair_ok_s3  (pair_ok),
		.mask_s3     (check_mask),
		.large_s3    (large_type)
	);

	`LBPQ_ASSERT_IMPL(a_stall_only_full, in_stall, v1 && v2 && v3 && out_stall)
	`LBPQ_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, v1)
	`LBPQ_ASSERT_NEXT(a_s2_moves_on, v2 && en3, v3)

endmodule
